>>> hw/rtl/mseu_pkg.sv
package mseu_pkg;

  // Widths of the instruction fields as they arrive on the input channel.
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned LINE_W  = 10;

  // Register file depth default; the top level carries it as a parameter.
  localparam int unsigned REGISTER_COUNT_DEF = 32;

  // Program memory size in lines. The counter wraps modulo this value.
  localparam int unsigned PROGRAM_LINES = 1024;
  localparam int unsigned PC_W          = $clog2(PROGRAM_LINES);

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD  = 3'd0,
    KIND_SUB  = 3'd1,
    KIND_MUL  = 3'd2,
    KIND_SLT  = 3'd3,
    KIND_ADDI = 3'd4,
    KIND_BNE  = 3'd5,
    KIND_BEQ  = 3'd6,
    KIND_JUMP = 3'd7
  } kind_t;

endpackage

>>> hw/rtl/mips_subset_execute_unit.sv
// Execute stage for a small MIPS-like integer subset (add, sub, mul low word, slt,
// addi, bne, beq, jump) with its own register file and program counter. The unit
// accepts one instruction beat per clock and delivers one result beat per
// instruction, in order. A result reaches the output register through the read
// stage: acceptance captures both operands from the two-read-port register file
// into registers, and when the execute stage fires it runs the ALU (including a
// single 32x32 multiplier), loads the result register and writes the register
// file back. A write in the second stage is forwarded to an instruction being
// read in the same cycle, so back-to-back dependent instructions need no
// bubbles; throughput is therefore limited only by output back-pressure. Register
// zero and indices at or above REGISTER_COUNT read as zero and are never written.
// Reset clears the register file at once through per-entry valid bits, so the
// unit is ready as soon as reset is released. A branch or jump whose target is
// flagged unknown raises label_error, is not taken, and the counter advances.
module mips_subset_execute_unit
  import mseu_pkg::*;
#(
  parameter int unsigned REGISTER_COUNT = REGISTER_COUNT_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,

  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [KIND_W-1:0]        in_kind,
  input  logic [IDX_W-1:0]         in_dest_index,
  input  logic [IDX_W-1:0]         in_src_a_index,
  input  logic [IDX_W-1:0]         in_src_b_index,
  input  logic signed [DATA_W-1:0] in_immediate,
  input  logic [LINE_W-1:0]        in_target_line,
  input  logic                     in_target_known,

  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_write_enable,
  output logic [IDX_W-1:0]         out_write_index,
  output logic signed [DATA_W-1:0] out_write_value,
  output logic                     out_branch_taken,
  output logic [LINE_W-1:0]        out_program_counter,
  output logic                     out_label_error
);

  localparam int unsigned RIDX_W = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
  localparam int unsigned EXT_W  = RIDX_W + IDX_W;

  // Register file storage and per-entry valid bits (an entry never written
  // since reset reads as zero).
  logic [DATA_W-1:0] rf_mem [REGISTER_COUNT];
  logic [REGISTER_COUNT-1:0] rf_valid_r;

  // Read stage registers.
  logic              s1_valid_r;
  kind_t             s1_kind_r;
  logic [IDX_W-1:0]  s1_dest_r;
  logic [DATA_W-1:0] s1_imm_r;
  logic [LINE_W-1:0] s1_target_r;
  logic              s1_known_r;
  logic [DATA_W-1:0] rd_a_raw_r;
  logic [DATA_W-1:0] rd_b_raw_r;
  logic              rd_a_zero_r;
  logic              rd_b_zero_r;
  logic              rd_a_fwd_r;
  logic              rd_b_fwd_r;
  logic [DATA_W-1:0] fwd_value_r;

  // Execute stage and output registers.
  logic              out_valid_r;
  logic              out_write_enable_r;
  logic [IDX_W-1:0]  out_write_index_r;
  logic [DATA_W-1:0] out_write_value_r;
  logic              out_branch_taken_r;
  logic              out_label_error_r;
  logic [PC_W-1:0]   pc_r;

  logic              in_fire;
  logic              s2_fire;

  // Port 1 serves the second source for ALU ops and the first compared
  // register for bne and beq.
  kind_t             in_kind_t;
  logic [IDX_W-1:0]  rd_b_index;
  logic [EXT_W-1:0]  rd_a_ext;
  logic [EXT_W-1:0]  rd_b_ext;
  logic [RIDX_W-1:0] rd_a_addr;
  logic [RIDX_W-1:0] rd_b_addr;
  logic              rd_a_hit;
  logic              rd_b_hit;
  logic              rd_a_zero_nxt;
  logic              rd_b_zero_nxt;

  logic [DATA_W-1:0] op_a;
  logic [DATA_W-1:0] op_b;
  logic [DATA_W-1:0] mul_lo;
  logic [DATA_W-1:0] alu_result;
  logic              alu_writes;
  logic              taken_nxt;
  logic              lerr_nxt;
  logic [EXT_W-1:0]  dest_ext;
  logic [RIDX_W-1:0] wr_addr;
  logic              wr_en_nxt;
  logic [PC_W-1:0]   pc_inc;
  logic [PC_W-1:0]   pc_target;
  logic [PC_W-1:0]   pc_nxt;

  assign in_fire  = in_valid && in_ready;
  assign s2_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s2_fire;

  // ---------------------------------------------------------------------------
  // Operand read, with forwarding from the write that retires in this cycle.
  // ---------------------------------------------------------------------------
  assign in_kind_t  = kind_t'(in_kind);
  assign rd_b_index = (in_kind_t == KIND_BNE || in_kind_t == KIND_BEQ) ?
                      in_dest_index : in_src_b_index;
  assign rd_a_ext   = EXT_W'(in_src_a_index);
  assign rd_b_ext   = EXT_W'(rd_b_index);
  assign rd_a_addr  = rd_a_ext[RIDX_W-1:0];
  assign rd_b_addr  = rd_b_ext[RIDX_W-1:0];

  // The write address is never zero and always in range, so a hit implies a
  // real register.
  assign rd_a_hit = wr_en_nxt && s2_fire && (rd_a_ext == dest_ext);
  assign rd_b_hit = wr_en_nxt && s2_fire && (rd_b_ext == dest_ext);

  assign rd_a_zero_nxt = (in_src_a_index == '0) ||
                         (rd_a_ext >= EXT_W'(REGISTER_COUNT)) ||
                         !rf_valid_r[rd_a_addr];
  assign rd_b_zero_nxt = (rd_b_index == '0) ||
                         (rd_b_ext >= EXT_W'(REGISTER_COUNT)) ||
                         !rf_valid_r[rd_b_addr];

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_a_raw_r <= rf_mem[rd_a_addr];
      rd_b_raw_r <= rf_mem[rd_b_addr];
    end
    if (s2_fire && wr_en_nxt) begin
      rf_mem[wr_addr] <= alu_result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_valid_r <= '0;
    end else if (s2_fire && wr_en_nxt) begin
      rf_valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r   <= in_kind_t;
      s1_dest_r   <= in_dest_index;
      s1_imm_r    <= in_immediate;
      s1_target_r <= in_target_line;
      s1_known_r  <= in_target_known;
      rd_a_fwd_r  <= rd_a_hit;
      rd_b_fwd_r  <= rd_b_hit;
      rd_a_zero_r <= rd_a_zero_nxt && !rd_a_hit;
      rd_b_zero_r <= rd_b_zero_nxt && !rd_b_hit;
      fwd_value_r <= alu_result;
    end
  end

  // ---------------------------------------------------------------------------
  // Execute: ALU, branch decision and next program counter.
  // ---------------------------------------------------------------------------
  assign op_a = rd_a_fwd_r ? fwd_value_r : (rd_a_zero_r ? '0 : rd_a_raw_r);
  assign op_b = rd_b_fwd_r ? fwd_value_r : (rd_b_zero_r ? '0 : rd_b_raw_r);

  assign mul_lo = op_a * op_b;

  always_comb begin
    alu_result = '0;
    alu_writes = 1'b0;
    taken_nxt  = 1'b0;
    lerr_nxt   = 1'b0;
    unique case (s1_kind_r)
      KIND_ADD: begin
        alu_result = op_a + op_b;
        alu_writes = 1'b1;
      end
      KIND_SUB: begin
        alu_result = op_a - op_b;
        alu_writes = 1'b1;
      end
      KIND_MUL: begin
        alu_result = mul_lo;
        alu_writes = 1'b1;
      end
      KIND_SLT: begin
        alu_result = DATA_W'($signed(op_a) < $signed(op_b));
        alu_writes = 1'b1;
      end
      KIND_ADDI: begin
        alu_result = op_a + s1_imm_r;
        alu_writes = 1'b1;
      end
      KIND_BNE: begin
        lerr_nxt  = !s1_known_r;
        taken_nxt = s1_known_r && (op_b != op_a);
      end
      KIND_BEQ: begin
        lerr_nxt  = !s1_known_r;
        taken_nxt = s1_known_r && (op_b == op_a);
      end
      KIND_JUMP: begin
        lerr_nxt  = !s1_known_r;
        taken_nxt = s1_known_r;
      end
    endcase
  end

  assign dest_ext  = EXT_W'(s1_dest_r);
  assign wr_addr   = dest_ext[RIDX_W-1:0];
  assign wr_en_nxt = alu_writes && (s1_dest_r != '0) &&
                     (dest_ext < EXT_W'(REGISTER_COUNT));

  assign pc_inc    = (pc_r == PC_W'(PROGRAM_LINES - 1)) ? '0 : pc_r + PC_W'(1);
  assign pc_target = PC_W'(s1_target_r % PROGRAM_LINES);
  assign pc_nxt    = taken_nxt ? pc_target : pc_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pc_r        <= '0;
    end else begin
      if (s2_fire) begin
        out_valid_r <= 1'b1;
        pc_r        <= pc_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_write_enable_r <= wr_en_nxt;
      out_write_index_r  <= wr_en_nxt ? s1_dest_r : '0;
      out_write_value_r  <= wr_en_nxt ? alu_result : '0;
      out_branch_taken_r <= taken_nxt;
      out_label_error_r  <= lerr_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_write_enable    = out_write_enable_r;
  assign out_write_index     = out_write_index_r;
  assign out_write_value     = out_write_value_r;
  assign out_branch_taken    = out_branch_taken_r;
  assign out_label_error     = out_label_error_r;
  assign out_program_counter = LINE_W'(pc_r);

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_zero_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_enable |-> out_write_index != '0)
    else $error("register zero reported as written");

  a_lerr_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_label_error |-> !out_branch_taken && !out_write_enable)
    else $error("label error together with a branch or a write");

  a_pc_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s2_fire && !taken_nxt |=> pc_r == $past(pc_inc))
    else $error("program counter did not advance by one line");

  a_pc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s2_fire |=> $stable(pc_r))
    else $error("program counter changed without a retiring instruction");

endmodule
